// ----- design/easing_interpolator_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the easing interpolator
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EASING_INTERPOLATOR_TOP_MACROS_SVH
`define EASING_INTERPOLATOR_TOP_MACROS_SVH

// Expression must hold at every edge outside reset.
`define EI_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent at an edge implies consequent starting at the same edge.
`define EI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/ei_pkg.sv -----
// ----------------------------------------------------------------------------
// ei_pkg
// Curve selector codes for the easing interpolator.
// ----------------------------------------------------------------------------
package ei_pkg;

    localparam logic [2:0] CMD_LINEAR   = 3'd0;
    localparam logic [2:0] CMD_SQUARE   = 3'd1;
    localparam logic [2:0] CMD_CUBIC    = 3'd2;
    localparam logic [2:0] CMD_QUARTIC  = 3'd3;
    localparam logic [2:0] CMD_REV_SQR  = 3'd4;
    localparam logic [2:0] CMD_REV_CUBE = 3'd5;

    localparam int CMD_BITS = 3;
    localparam int OUT_BITS = 32;

endpackage

// ----- design/easing_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// easing_interpolator_top
// Pipelined easing-curve interpolation with exact truncating division.
// ----------------------------------------------------------------------------
// Takes one transaction per clock (busy is always low) and returns each
// result on value/saturated with a one-cycle done strobe, in order, after
// the decode and power stages, the restoring divider and an output register.
// The restoring divider resolves one quotient bit per stage. Results cannot
// be held off by the receiver.
module easing_interpolator_top #(
    parameter int POS_BITS   = 8,
    parameter int VALUE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [ei_pkg::CMD_BITS-1:0]          cmd,
    input  logic signed [VALUE_BITS-1:0]         start_value,
    input  logic signed [VALUE_BITS-1:0]         end_value,
    input  logic [POS_BITS-1:0]                  position,
    input  logic [POS_BITS-1:0]                  span,
    output logic                                 done,
    output logic signed [ei_pkg::OUT_BITS-1:0]   value,
    output logic                                 saturated
);
    import ei_pkg::*;

    localparam int P  = POS_BITS;
    localparam int VB = VALUE_BITS;
    localparam int DW = VB + 1;
    localparam int PW = 4 * P;
    localparam int NW = DW + PW;
    localparam int RW = (NW + 2 > OUT_BITS + 1) ? NW + 2 : OUT_BITS + 1;

    localparam logic signed [RW-1:0] SMAX = {{(RW-OUT_BITS){1'b0}}, 1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [RW-1:0] SMIN = {{(RW-OUT_BITS){1'b1}}, 1'b1, {(OUT_BITS-1){1'b0}}};

    assign busy = 1'b0;

    // ---------------- stage 1: decode ----------------
    logic signed [DW-1:0] diff;
    logic                 dneg;
    logic [DW-1:0]        dmag;
    logic [P-1:0]         b_next;
    logic [1:0]           k_next;
    logic signed [VB-1:0] base_next;
    logic                 up_next;
    logic                 kill_next;
    logic                 xneg;

    always_comb
    begin
        diff      = DW'(end_value) - DW'(start_value);
        dneg      = diff[DW-1];
        dmag      = dneg ? DW'(-diff) : DW'(diff);
        xneg      = position > span;
        b_next    = position;
        k_next    = 2'd0;
        base_next = start_value;
        up_next   = !dneg;
        kill_next = 1'b0;
        if (span == '0)
        begin
            base_next = end_value;
            up_next   = 1'b1;
            kill_next = 1'b1;
        end
        else
        begin
            unique case (cmd) inside
                CMD_LINEAR, CMD_SQUARE, CMD_CUBIC, CMD_QUARTIC:
                begin
                    k_next = cmd[1:0];
                end
                CMD_REV_SQR, CMD_REV_CUBE:
                begin
                    b_next    = xneg ? P'(position - span) : P'(span - position);
                    k_next    = (cmd == CMD_REV_SQR) ? 2'd1 : 2'd2;
                    base_next = end_value;
                    // odd power of a negative distance flips direction
                    up_next   = dneg != (xneg && cmd == CMD_REV_CUBE);
                end
                default:
                begin
                    base_next = '0;
                    up_next   = 1'b1;
                    kill_next = 1'b1;
                end
            endcase
        end
    end

    logic                 v1_reg, v2_reg, v3_reg;
    logic [P-1:0]         b1_reg, xm1_reg;
    logic [1:0]           k1_reg, k2_reg, k3_reg;
    logic [DW-1:0]        dm1_reg, dm2_reg, dm3_reg;
    logic signed [VB-1:0] base1_reg, base2_reg, base3_reg;
    logic                 up1_reg, up2_reg, up3_reg;
    logic                 kill1_reg, kill2_reg, kill3_reg;
    logic [P-1:0]         b2p_reg, xm2p_reg;
    logic [2*P-1:0]       b2_reg, xm2_reg;
    logic [PW-1:0]        pb3_reg, px3_reg;

    logic [PW-1:0]        pb_next, px_next;
    logic [3*P-1:0]       b3_w, x3_w;
    logic [4*P-1:0]       b4_w, x4_w;

    always_comb
    begin
        b3_w = b2_reg * (3*P)'(b2p_reg);
        x3_w = xm2_reg * (3*P)'(xm2p_reg);
        b4_w = (4*P)'(b2_reg) * (4*P)'(b2_reg);
        x4_w = (4*P)'(xm2_reg) * (4*P)'(xm2_reg);
        case (k2_reg)
            2'd0:    begin pb_next = PW'(b2p_reg); px_next = PW'(xm2p_reg); end
            2'd1:    begin pb_next = PW'(b2_reg);  px_next = PW'(xm2_reg);  end
            2'd2:    begin pb_next = PW'(b3_w);    px_next = PW'(x3_w);     end
            default: begin pb_next = b4_w;         px_next = x4_w;          end
        endcase
    end

    // ---------------- divider stage array ----------------
    logic              dv_reg   [0:NW];
    logic [NW-1:0]     nq_reg   [0:NW];
    logic [PW-1:0]     rem_reg  [0:NW];
    logic [PW-1:0]     den_reg  [0:NW];
    logic signed [VB-1:0] dbase_reg [0:NW];
    logic              dup_reg  [0:NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
        end
        else
        begin
            v1_reg    <= start && !busy;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            dv_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg    <= b_next;
        xm1_reg   <= span;
        k1_reg    <= k_next;
        dm1_reg   <= dmag;
        base1_reg <= base_next;
        up1_reg   <= up_next;
        kill1_reg <= kill_next;

        b2p_reg   <= b1_reg;
        xm2p_reg  <= xm1_reg;
        b2_reg    <= (2*P)'(b1_reg) * (2*P)'(b1_reg);
        xm2_reg   <= (2*P)'(xm1_reg) * (2*P)'(xm1_reg);
        k2_reg    <= k1_reg;
        dm2_reg   <= dm1_reg;
        base2_reg <= base1_reg;
        up2_reg   <= up1_reg;
        kill2_reg <= kill1_reg;

        pb3_reg   <= pb_next;
        px3_reg   <= px_next;
        k3_reg    <= k2_reg;
        dm3_reg   <= dm2_reg;
        base3_reg <= base2_reg;
        up3_reg   <= up2_reg;
        kill3_reg <= kill2_reg;

        // killed items divide zero by one
        nq_reg[0]    <= kill3_reg ? '0 : NW'(dm3_reg) * NW'(pb3_reg);
        den_reg[0]   <= kill3_reg ? PW'(1) : px3_reg;
        rem_reg[0]   <= '0;
        dbase_reg[0] <= base3_reg;
        dup_reg[0]   <= up3_reg;
    end

    for (genvar g = 1; g <= NW; g++)
    begin : g_div
        logic [PW:0] sh;
        logic [PW:0] sub;
        logic        ge;

        assign sh  = {rem_reg[g-1], nq_reg[g-1][NW-1]};
        assign sub = sh - {1'b0, den_reg[g-1]};
        assign ge  = sh >= {1'b0, den_reg[g-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[g] <= 1'b0;
            end
            else
            begin
                dv_reg[g] <= dv_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g]   <= ge ? sub[PW-1:0] : sh[PW-1:0];
            nq_reg[g]    <= {nq_reg[g-1][NW-2:0], ge};
            den_reg[g]   <= den_reg[g-1];
            dbase_reg[g] <= dbase_reg[g-1];
            dup_reg[g]   <= dup_reg[g-1];
        end
    end

    // ---------------- final add and saturate ----------------
    logic signed [RW-1:0] base_ext;
    logic signed [RW-1:0] q_ext;
    logic signed [RW-1:0] sum;
    logic signed [OUT_BITS-1:0] value_next;
    logic                 sat_next;

    always_comb
    begin
        base_ext = RW'(dbase_reg[NW]);
        q_ext    = $signed({{(RW-NW){1'b0}}, nq_reg[NW]});
        sum      = dup_reg[NW] ? base_ext + q_ext : base_ext - q_ext;
        if (sum > SMAX)
        begin
            value_next = SMAX[OUT_BITS-1:0];
            sat_next   = 1'b1;
        end
        else if (sum < SMIN)
        begin
            value_next = SMIN[OUT_BITS-1:0];
            sat_next   = 1'b1;
        end
        else
        begin
            value_next = sum[OUT_BITS-1:0];
            sat_next   = 1'b0;
        end
    end

    logic                       done_reg;
    logic signed [OUT_BITS-1:0] value_reg;
    logic                       saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        saturated_reg <= sat_next;
    end

    assign done      = done_reg;
    assign value     = value_reg;
    assign saturated = saturated_reg;

endmodule

// ----- design/ei_checker.sv -----
// ----------------------------------------------------------------------------
// ei_checker
// Port-level checks on the easing interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`include "easing_interpolator_top_macros.svh"

module ei_checker #(
    parameter int POS_BITS   = 8,
    parameter int VALUE_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [ei_pkg::CMD_BITS-1:0]   cmd,
    input logic signed [VALUE_BITS-1:0]  start_value,
    input logic signed [VALUE_BITS-1:0]  end_value,
    input logic [POS_BITS-1:0]           position,
    input logic [POS_BITS-1:0]           span,
    input logic                          done,
    input logic signed [ei_pkg::OUT_BITS-1:0] value,
    input logic                          saturated
);
    import ei_pkg::*;

    localparam int LAT = 5 + VALUE_BITS + 1 + 4 * POS_BITS;

    `EI_ASSERT_ALWAYS(a_no_busy, !busy, "busy asserted")
    `EI_ASSERT_IMPL(a_latency, start && !busy, ##LAT done,
        "done missing at fixed latency after start")
    `EI_ASSERT_IMPL(a_done_source, done, $past(start && !busy, LAT),
        "done without a start at fixed latency")
    `EI_ASSERT_IMPL(a_sat_value, done && saturated,
        value == 32'sh7fffffff || value == 32'sh80000000, "saturated with in-range value")
    `EI_ASSERT_IMPL(a_zero_span, done && $past(span, LAT) == '0,
        value == OUT_BITS'($past(end_value, LAT)) && !saturated,
        "zero span does not return end value")

endmodule

bind easing_interpolator_top ei_checker #(
    .POS_BITS   (POS_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_ei_checker (.*);
